// ===== design/vpc_pkg.sv =====
package vpc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int CORDIC_STEPS = 23;
  localparam int TAB_FRAC     = 16;  // atan table in 2^-16 degree
  localparam int VEC_SHIFT    = 24;  // pre-scale of |dx|, |dy| for vectoring
  localparam int GUARD        = 8;   // guard bits on rotation magnitude
  localparam int Z_W          = 26;  // angle accumulator width
  localparam int LEN_W        = 25;
  localparam int PART_W       = 26;
  localparam int ANG_W        = 17;
  localparam int ANGI_W       = 26;  // internal angle math width
  localparam int OUT_W        = 96;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic CMD_POLAR = 1'b0;  // points to polar
  localparam logic CMD_PARTS = 1'b1;  // polar to components

  typedef struct packed {
    logic       cmd;
    logic       zero_pt;
    logic       dx_zero;
    logic       dy_zero;
    logic       dx_neg;
    logic       dy_neg;
    logic       r_zero;
    logic [1:0] quad;
  } ctl_t;

  function automatic logic [22:0] atan_tab(input logic [4:0] idx);
    logic [22:0] t;
    case (idx)
      5'd0:  t = 23'd2949120;
      5'd1:  t = 23'd1740967;
      5'd2:  t = 23'd919879;
      5'd3:  t = 23'd466945;
      5'd4:  t = 23'd234379;
      5'd5:  t = 23'd117304;
      5'd6:  t = 23'd58666;
      5'd7:  t = 23'd29335;
      5'd8:  t = 23'd14668;
      5'd9:  t = 23'd7334;
      5'd10: t = 23'd3667;
      5'd11: t = 23'd1833;
      5'd12: t = 23'd917;
      5'd13: t = 23'd458;
      5'd14: t = 23'd229;
      5'd15: t = 23'd115;
      5'd16: t = 23'd57;
      5'd17: t = 23'd29;
      5'd18: t = 23'd14;
      5'd19: t = 23'd7;
      5'd20: t = 23'd4;
      5'd21: t = 23'd2;
      5'd22: t = 23'd1;
      default: t = 23'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== design/vpc_prep.sv =====
module vpc_prep import vpc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  parameter int DW = 44,
  parameter int RB = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic                   cmd,
  input  logic signed [CW-1:0]   sx,
  input  logic signed [CW-1:0]   sy,
  input  logic signed [CW-1:0]   ex,
  input  logic signed [CW-1:0]   ey,
  input  logic [LEN_W-1:0]       plen,
  input  logic [ANG_W-1:0]       pang,
  output logic                   out_valid,
  output ctl_t                   out_ctl,
  output logic signed [CW:0]     out_dx,
  output logic signed [CW:0]     out_dy,
  output logic [LEN_W-1:0]       out_len,
  output logic [ANG_W-1:0]       out_ang,
  output logic signed [DW-1:0]   out_x,
  output logic signed [DW-1:0]   out_y,
  output logic signed [Z_W-1:0]  out_z,
  output logic [2*RB-1:0]        out_rad
);

  localparam logic [ANGI_W-1:0] D90  = ANGI_W'(90 << FB);
  localparam logic [ANGI_W-1:0] D180 = ANGI_W'(180 << FB);
  localparam logic [ANGI_W-1:0] D270 = ANGI_W'(270 << FB);
  localparam logic [ANGI_W-1:0] D360 = ANGI_W'(360 << FB);
  localparam int LX_W = LEN_W + 30;
  localparam int SQ_W = 2*CW + 2;

  // stage 1: differences, magnitudes, angle split
  logic signed [CW:0]  dx_c, dy_c;
  logic [CW:0]         ax_c, ay_c;
  logic [ANGI_W-1:0]   a_c, r_c;
  logic [1:0]          q_c;

  always_comb begin
    dx_c = {ex[CW-1], ex} - {sx[CW-1], sx};
    dy_c = {ey[CW-1], ey} - {sy[CW-1], sy};
    ax_c = dx_c[CW] ? (CW+1)'(-dx_c) : dx_c;
    ay_c = dy_c[CW] ? (CW+1)'(-dy_c) : dy_c;
    a_c  = ANGI_W'(pang);
    if (a_c > D360 - 1'b1) a_c = D360 - 1'b1;
    if (a_c >= D270) begin
      q_c = 2'd3; r_c = a_c - D270;
    end else if (a_c >= D180) begin
      q_c = 2'd2; r_c = a_c - D180;
    end else if (a_c >= D90) begin
      q_c = 2'd1; r_c = a_c - D90;
    end else begin
      q_c = 2'd0; r_c = a_c;
    end
  end

  logic                v1, v2;
  ctl_t                ctl1, ctl2;
  logic signed [CW:0]  dx1, dy1, dx2, dy2;
  logic [CW:0]         ax1, ay1, ax2, ay2;
  logic [LEN_W-1:0]    len1, len2;
  logic [ANG_W-1:0]    ang1, ang2;
  logic [ANGI_W-1:0]   r1, r2;
  logic [SQ_W-1:0]     sqx2, sqy2;
  logic [LX_W-1:0]     lx2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1.cmd     <= cmd;
      ctl1.zero_pt <= (dx_c == '0) && (dy_c == '0);
      ctl1.dx_zero <= (dx_c == '0);
      ctl1.dy_zero <= (dy_c == '0);
      ctl1.dx_neg  <= dx_c[CW];
      ctl1.dy_neg  <= dy_c[CW];
      ctl1.r_zero  <= (r_c == '0);
      ctl1.quad    <= q_c;
      dx1  <= dx_c;
      dy1  <= dy_c;
      ax1  <= ax_c;
      ay1  <= ay_c;
      len1 <= plen;
      ang1 <= a_c[ANG_W-1:0];
      r1   <= r_c;
      // stage 2: squares and gain-compensated magnitude
      ctl2 <= ctl1;
      dx2  <= dx1;
      dy2  <= dy1;
      ax2  <= ax1;
      ay2  <= ay1;
      len2 <= len1;
      ang2 <= ang1;
      r2   <= r1;
      sqx2 <= ax1 * ax1;
      sqy2 <= ay1 * ay1;
      lx2  <= LX_W'(len1) * LX_W'(INV_GAIN_Q30);
      // stage 3: radicand and CORDIC seeds
      out_ctl <= ctl2;
      out_dx  <= dx2;
      out_dy  <= dy2;
      out_len <= len2;
      out_ang <= ang2;
      out_rad <= (2*RB)'(SQ_W'(sqx2 + sqy2)) << (2*FB);
      if (ctl2.cmd == CMD_POLAR) begin
        out_x <= $signed(DW'(ax2) << VEC_SHIFT);
        out_y <= $signed(DW'(ay2) << VEC_SHIFT);
        out_z <= '0;
      end else begin
        out_x <= $signed(DW'((lx2 + LX_W'(1 << (29 - GUARD))) >> (30 - GUARD)));
        out_y <= '0;
        out_z <= $signed(Z_W'(r2) << (TAB_FRAC - FB));
      end
    end
  end

endmodule

// ===== design/vpc_step.sv =====
module vpc_step import vpc_pkg::*; #(
  parameter int DW  = 44,
  parameter int RB  = 25,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  polar,
  input  logic signed [DW-1:0]  x_in,
  input  logic signed [DW-1:0]  y_in,
  input  logic signed [Z_W-1:0] z_in,
  input  logic [2*RB-1:0]       rad_in,
  input  logic [RB+1:0]         rem_in,
  input  logic [RB-1:0]         root_in,
  output logic signed [DW-1:0]  x_out,
  output logic signed [DW-1:0]  y_out,
  output logic signed [Z_W-1:0] z_out,
  output logic [2*RB-1:0]       rad_out,
  output logic [RB+1:0]         rem_out,
  output logic [RB-1:0]         root_out
);

  logic signed [DW-1:0]  x_next, y_next;
  logic signed [Z_W-1:0] z_next;
  logic [2*RB-1:0]       rad_next;
  logic [RB+1:0]         rem_next;
  logic [RB-1:0]         root_next;

  generate
    if (IDX < CORDIC_STEPS) begin : g_cordic
      logic signed [DW-1:0]  xs, ys;
      logic signed [Z_W-1:0] t;
      logic                  sel_a;
      always_comb begin
        // shifts truncate toward zero
        xs = x_in[DW-1] ? -((-x_in) >>> IDX) : (x_in >>> IDX);
        ys = y_in[DW-1] ? -((-y_in) >>> IDX) : (y_in >>> IDX);
        t  = $signed(Z_W'(atan_tab(5'(IDX))));
        // vectoring drives y to zero, rotation drives z to zero
        sel_a = polar ? (y_in > 0) : z_in[Z_W-1];
        if (sel_a) begin
          x_next = x_in + ys;
          y_next = y_in - xs;
          z_next = z_in + t;
        end else begin
          x_next = x_in - ys;
          y_next = y_in + xs;
          z_next = z_in - t;
        end
      end
    end else begin : g_cordic_pass
      always_comb begin
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
      end
    end

    if (IDX < RB) begin : g_sqrt
      logic [RB+2:0] rem2, trial;
      always_comb begin
        rem2  = {rem_in[RB:0], rad_in[2*RB-1 -: 2]};
        trial = {1'b0, root_in, 2'b01};
        rad_next = rad_in << 2;
        if (rem2 >= trial) begin
          rem_next  = (RB+2)'(rem2 - trial);
          root_next = {root_in[RB-2:0], 1'b1};
        end else begin
          rem_next  = (RB+2)'(rem2);
          root_next = {root_in[RB-2:0], 1'b0};
        end
      end
    end else begin : g_sqrt_pass
      always_comb begin
        rad_next  = rad_in;
        rem_next  = rem_in;
        root_next = root_in;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_next;
      y_out    <= y_next;
      z_out    <= z_next;
      rad_out  <= rad_next;
      rem_out  <= rem_next;
      root_out <= root_next;
    end
  end

endmodule

// ===== design/vpc_post.sv =====
module vpc_post import vpc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  parameter int DW = 44,
  parameter int RB = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  ctl_t                      ctl,
  input  logic signed [CW:0]        dx,
  input  logic signed [CW:0]        dy,
  input  logic [LEN_W-1:0]          len,
  input  logic [ANG_W-1:0]          ang,
  input  logic signed [DW-1:0]      x,
  input  logic signed [DW-1:0]      y,
  input  logic signed [Z_W-1:0]     z,
  input  logic [RB+1:0]             rem,
  input  logic [RB-1:0]             root,
  output logic                      out_valid,
  output logic signed [PART_W-1:0]  x_part,
  output logic signed [PART_W-1:0]  y_part,
  output logic [LEN_W-1:0]          length,
  output logic [ANG_W-1:0]          angle
);

  localparam logic [ANGI_W-1:0] D90  = ANGI_W'(90 << FB);
  localparam logic [ANGI_W-1:0] D180 = ANGI_W'(180 << FB);
  localparam logic [ANGI_W-1:0] D270 = ANGI_W'(270 << FB);
  localparam logic [ANGI_W-1:0] D360 = ANGI_W'(360 << FB);
  localparam logic signed [Z_W-1:0] D90T = Z_W'(90 << TAB_FRAC);
  localparam int SH  = TAB_FRAC - FB;
  localparam int RND = (SH == 0) ? 0 : (1 << (SH - 1));
  localparam int RX  = (RB + 1 > LEN_W + 1) ? RB + 1 : LEN_W + 1;
  localparam int XW  = (CW + 1 + FB > PART_W) ? CW + 1 + FB : PART_W;

  logic [RX-1:0]              rr;
  logic [LEN_W-1:0]           len_s;
  logic signed [Z_W-1:0]      zc;
  logic [ANGI_W-1:0]          phi, a_c;
  logic signed [XW-1:0]       dxs, dys;
  logic signed [DW-1:0]       xr, yr, lim;
  logic [LEN_W-1:0]           c, s;
  logic signed [PART_W-1:0]   cs, ss;
  logic signed [PART_W-1:0]   xo, yo;
  logic [LEN_W-1:0]           lo;
  logic [ANG_W-1:0]           ao;

  always_comb begin
    // magnitude: round root to nearest, saturate
    rr = RX'(root) + RX'(rem > (RB+2)'(root));
    len_s = (rr > RX'(LEN_MAX)) ? LEN_MAX : rr[LEN_W-1:0];

    // first-quadrant angle clamped to [0, 90] then rounded
    zc = z;
    if (z < 0) zc = '0;
    else if (z > D90T) zc = D90T;
    phi = ANGI_W'((zc + Z_W'(RND)) >>> SH);

    // map to quadrant: off-axis directions stay strictly inside it, axis directions land on 0, 90, 180 or 270
    if (ctl.dx_zero) begin
      a_c = ctl.dy_neg ? D270 : D90;
    end else if (ctl.dy_zero) begin
      a_c = ctl.dx_neg ? D180 : '0;
    end else if (!ctl.dx_neg && !ctl.dy_neg) begin
      a_c = (phi == '0) ? ANGI_W'(1) : ((phi >= D90) ? D90 - 1'b1 : phi);
    end else if (ctl.dx_neg && !ctl.dy_neg) begin
      a_c = (phi == '0) ? D180 - 1'b1 : ((phi >= D90) ? D90 + 1'b1 : D180 - phi);
    end else if (ctl.dx_neg) begin
      a_c = (phi == '0) ? D180 + 1'b1 : ((phi >= D90) ? D270 - 1'b1 : D180 + phi);
    end else begin
      a_c = (phi == '0) ? D360 - 1'b1 : ((phi >= D90) ? D270 + 1'b1 : D360 - phi);
    end

    dxs = XW'(dx) <<< FB;
    dys = XW'(dy) <<< FB;

    // components: round guard bits off, clamp to [0, magnitude]
    lim = $signed(DW'(len));
    xr  = (x + DW'(1 << (GUARD - 1))) >>> GUARD;
    yr  = (y + DW'(1 << (GUARD - 1))) >>> GUARD;
    c = (x <= 0) ? '0 : ((xr > lim) ? len : xr[LEN_W-1:0]);
    s = (y <= 0) ? '0 : ((yr > lim) ? len : yr[LEN_W-1:0]);
    if (ctl.r_zero) begin
      c = len;
      s = '0;
    end
    cs = $signed({1'b0, c});
    ss = $signed({1'b0, s});

    if (ctl.cmd == CMD_POLAR) begin
      if (ctl.zero_pt) begin
        xo = '0; yo = '0; lo = '0; ao = '0;
      end else begin
        xo = dxs[PART_W-1:0];
        yo = dys[PART_W-1:0];
        lo = len_s;
        ao = a_c[ANG_W-1:0];
      end
    end else begin
      lo = len;
      ao = ang;
      case (ctl.quad)
        2'd0: begin xo = cs;  yo = ss;  end
        2'd1: begin xo = -ss; yo = cs;  end
        2'd2: begin xo = -cs; yo = -ss; end
        default: begin xo = ss; yo = -cs; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_part <= xo;
      y_part <= yo;
      length <= lo;
      angle  <= ao;
    end
  end

endmodule

// ===== design/vector_polar_convert_unit.sv =====
// Rectangular/polar converter, fully pipelined: one item per clock while the
// output is not stalled. An item passes through three prep stages, one stage
// per step of the longer of the 23-step CORDIC and the one-bit-per-stage
// square root that run side by side, and one output stage. tuser = 0 turns
// two points into dx, dy, magnitude and a direction in 1/256 degree; tuser = 1
// turns a magnitude and a direction into signed components. The whole pipe
// advances together and freezes while a result sits unread at the output, so
// s_tready is simply "output register free or being emptied"; no item is lost
// or duplicated under any stall.
module vector_polar_convert_unit import vpc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int IN_W = ((4*COORD_WIDTH + LEN_W + ANG_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // start_x, start_y, end_x, end_y, polar_length, polar_angle, zero pad
  input  logic [IN_W-1:0]  s_tdata,
  // command
  input  logic             s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // x_part, y_part, length, angle, zero pad
  output logic [OUT_W-1:0] m_tdata
);

  localparam int CW = COORD_WIDTH;
  localparam int RB = COORD_WIDTH + FRAC_BITS + 1;          // root bits
  localparam int NS = (RB > CORDIC_STEPS) ? RB : CORDIC_STEPS;
  localparam int DW = (COORD_WIDTH + 28 > 37) ? COORD_WIDTH + 28 : 37;
  localparam int LEN_LO = 4*CW;
  localparam int ANG_LO = 4*CW + LEN_W;
  localparam int OANG_LO = 2*PART_W + LEN_W;

  // global advance: output register empty or being taken
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // pipeline lines, index k feeds step k
  logic                   vld  [0:NS];
  ctl_t                   ctl  [0:NS];
  logic signed [CW:0]     dx   [0:NS];
  logic signed [CW:0]     dy   [0:NS];
  logic [LEN_W-1:0]       len  [0:NS];
  logic [ANG_W-1:0]       ang  [0:NS];
  logic signed [DW-1:0]   cx   [0:NS];
  logic signed [DW-1:0]   cy   [0:NS];
  logic signed [Z_W-1:0]  cz   [0:NS];
  logic [2*RB-1:0]        rad  [0:NS];
  logic [RB+1:0]          rem  [0:NS];
  logic [RB-1:0]          root [0:NS];

  vpc_prep #(.CW(CW), .FB(FRAC_BITS), .DW(DW), .RB(RB)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .cmd      (s_tuser),
    .sx       ($signed(s_tdata[CW-1:0])),
    .sy       ($signed(s_tdata[2*CW-1:CW])),
    .ex       ($signed(s_tdata[3*CW-1:2*CW])),
    .ey       ($signed(s_tdata[4*CW-1:3*CW])),
    .plen     (s_tdata[LEN_LO +: LEN_W]),
    .pang     (s_tdata[ANG_LO +: ANG_W]),
    .out_valid(vld[0]),
    .out_ctl  (ctl[0]),
    .out_dx   (dx[0]),
    .out_dy   (dy[0]),
    .out_len  (len[0]),
    .out_ang  (ang[0]),
    .out_x    (cx[0]),
    .out_y    (cy[0]),
    .out_z    (cz[0]),
    .out_rad  (rad[0])
  );

  // square root starts from an empty remainder and root
  assign rem[0]  = '0;
  assign root[0] = '0;

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_pipe
      vpc_step #(.DW(DW), .RB(RB), .IDX(k)) u_step (
        .clk     (clk),
        .en      (en),
        .polar   (ctl[k].cmd == CMD_POLAR),
        .x_in    (cx[k]),
        .y_in    (cy[k]),
        .z_in    (cz[k]),
        .rad_in  (rad[k]),
        .rem_in  (rem[k]),
        .root_in (root[k]),
        .x_out   (cx[k+1]),
        .y_out   (cy[k+1]),
        .z_out   (cz[k+1]),
        .rad_out (rad[k+1]),
        .rem_out (rem[k+1]),
        .root_out(root[k+1])
      );

      // side fields ride along with the item
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (en) begin
          vld[k+1] <= vld[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ctl[k+1] <= ctl[k];
          dx[k+1]  <= dx[k];
          dy[k+1]  <= dy[k];
          len[k+1] <= len[k];
          ang[k+1] <= ang[k];
        end
      end
    end
  endgenerate

  logic signed [PART_W-1:0] x_part, y_part;
  logic [LEN_W-1:0]         length;
  logic [ANG_W-1:0]         angle;

  vpc_post #(.CW(CW), .FB(FRAC_BITS), .DW(DW), .RB(RB)) u_post (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vld[NS]),
    .ctl      (ctl[NS]),
    .dx       (dx[NS]),
    .dy       (dy[NS]),
    .len      (len[NS]),
    .ang      (ang[NS]),
    .x        (cx[NS]),
    .y        (cy[NS]),
    .z        (cz[NS]),
    .rem      (rem[NS]),
    .root     (root[NS]),
    .out_valid(m_tvalid),
    .x_part   (x_part),
    .y_part   (y_part),
    .length   (length),
    .angle    (angle)
  );

  assign m_tdata = {(OUT_W - 2*PART_W - LEN_W - ANG_W)'(0), angle, length, y_part, x_part};

`ifndef ASSERT_OFF
  // a stalled pipe must not drop the item in the last step
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    vld[NS] && !en |=> vld[NS])
    else $error("item lost in last pipeline stage during stall");

  // backpressure only comes from an occupied output register
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // direction always below a full turn
  a_angle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OANG_LO +: ANG_W] <= ANG_W'((360 << FRAC_BITS) - 1)))
    else $error("angle out of range");
`endif

endmodule
